FILE: rtl/assert_macros.svh
// assert_macros.svh
// Shared concurrent assertion macros. Each one samples on clk and is
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every sampled edge.
`define BSA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BSA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants of the Bhaskara sine block
// Fixed-point constants (pi = 3.14 in Q3.12), datapath widths and the
// control word that travels along the pipeline.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int ANGLE_W = 16;    // Q3.12 input angle
    localparam int SINE_W  = 16;    // Q1.14 result
    localparam int X_W     = 17;    // angle during range reduction
    localparam int A_W     = 14;    // |x| after reduction, at most pi
    localparam int T_W     = 26;    // x * (pi - x), Q2.24
    localparam int DEN_W   = 30;    // 5*pi^2 - 4t
    localparam int HALF_W  = 29;    // den / 2
    localparam int DVD_W   = 44;    // 16t * 2^14 + den/2
    localparam int QUO_W   = 15;    // quotient never exceeds one in Q14

    localparam logic signed [X_W-1:0] PI_S     = 17'sd12861;
    localparam logic signed [X_W-1:0] NEG_PI_S = -17'sd12861;
    localparam logic signed [X_W-1:0] TWO_PI_S = 17'sd25722;
    localparam logic [A_W-1:0]        PI_U     = 14'd12861;

    // 5 * 12861^2 is odd, so den/2 = (5*pi^2 - 1)/2 - 2t exactly
    localparam logic [DEN_W-1:0]  FIVE_PI2      = 30'd827026605;
    localparam logic [HALF_W-1:0] HALF_FIVE_PI2 = 29'd413513302;

    localparam logic [QUO_W-1:0] ONE_Q14 = 15'd16384;

    // Register stages: prep (3), one per quotient bit, output register
    localparam int PREP_STAGES = 3;
    localparam int LATENCY     = PREP_STAGES + QUO_W + 1;

    typedef struct packed {
        logic valid;
        logic neg;
    } bsa_ctl_t;

endpackage

FILE: rtl/bsa_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_prep: range reduction and numerator / denominator setup
// Three stages: reduce into (-pi, pi] and take |x|, multiply x*(pi-x),
// then form the rounded dividend and the divisor for the cell chain.
// ----------------------------------------------------------------------------
module bsa_prep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [bsa_pkg::ANGLE_W-1:0]   angle,
    output bsa_pkg::bsa_ctl_t             ctl_out,
    output logic [bsa_pkg::DVD_W-1:0]     dvd_out,
    output logic [bsa_pkg::DEN_W-1:0]     den_out
);
    import bsa_pkg::*;

    logic signed [X_W-1:0] x_in;
    logic signed [X_W-1:0] x_red;
    logic signed [X_W-1:0] x_abs;
    logic [A_W-1:0]        a_next;
    logic [A_W-1:0]        a_reg;
    logic [2*A_W-1:0]      prod;
    logic [T_W-1:0]        t_next;
    logic [T_W-1:0]        t_reg;
    logic [DEN_W-1:0]      num;
    logic [HALF_W-1:0]     half_den;
    logic [DVD_W-1:0]      dvd_next;
    logic [DEN_W-1:0]      den_next;
    logic [DVD_W-1:0]      dvd_reg;
    logic [DEN_W-1:0]      den_reg;
    bsa_ctl_t              ctl1_next;
    bsa_ctl_t              ctl1_reg;
    bsa_ctl_t              ctl2_reg;
    bsa_ctl_t              ctl3_reg;

    // Reduce by one step of 2*pi, fold the sign off
    always_comb
    begin
        x_in = {angle[ANGLE_W-1], angle};
        if (x_in > PI_S)
            x_red = x_in - TWO_PI_S;
        else if (x_in <= NEG_PI_S)
            x_red = x_in + TWO_PI_S;
        else
            x_red = x_in;
        ctl1_next.valid = in_valid;
        ctl1_next.neg   = x_red[X_W-1];
        x_abs = x_red[X_W-1] ? -x_red : x_red;
        if (x_abs > PI_S)
            a_next = PI_U;
        else
            a_next = x_abs[A_W-1:0];
    end

    // t = a * (pi - a)
    always_comb
    begin
        prod   = {{A_W{1'b0}}, a_reg} * {{A_W{1'b0}}, PI_U - a_reg};
        t_next = prod[T_W-1:0];
    end

    // Dividend 16t * 2^14 + den/2, divisor 5pi^2 - 4t
    always_comb
    begin
        num      = {t_reg, 4'b0000};
        half_den = HALF_FIVE_PI2 - {2'b00, t_reg, 1'b0};
        den_next = FIVE_PI2 - {2'b00, t_reg, 2'b00};
        dvd_next = {num, {(DVD_W-DEN_W){1'b0}}} + {{(DVD_W-HALF_W){1'b0}}, half_den};
    end

    // Advance control words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    // Hold payload stages
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        t_reg   <= t_next;
        dvd_reg <= dvd_next;
        den_reg <= den_next;
    end

    assign ctl_out = ctl3_reg;
    assign dvd_out = dvd_reg;
    assign den_out = den_reg;

endmodule

FILE: rtl/bsa_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_div_cell: one restoring-division cell
// Resolves one quotient bit: subtract the shifted divisor when it fits,
// then hand remainder, divisor and quotient to the next cell.
// ----------------------------------------------------------------------------
module bsa_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bsa_pkg::bsa_ctl_t             ctl_in,
    input  logic [bsa_pkg::DVD_W-1:0]     rem_in,
    input  logic [bsa_pkg::DEN_W-1:0]     den_in,
    input  logic [bsa_pkg::QUO_W-1:0]     quo_in,
    output bsa_pkg::bsa_ctl_t             ctl_out,
    output logic [bsa_pkg::DVD_W-1:0]     rem_out,
    output logic [bsa_pkg::DEN_W-1:0]     den_out,
    output logic [bsa_pkg::QUO_W-1:0]     quo_out
);
    import bsa_pkg::*;

    logic [DVD_W-1:0] den_sh;
    logic             fits;
    logic [DVD_W-1:0] rem_next;
    logic [QUO_W-1:0] quo_next;
    bsa_ctl_t         ctl_reg;
    logic [DVD_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [QUO_W-1:0] quo_reg;

    // Trial subtract of the divisor at this bit weight
    always_comb
    begin
        den_sh   = {{(DVD_W-DEN_W){1'b0}}, den_in} << SHIFT;
        fits     = (rem_in >= den_sh);
        rem_next = fits ? (rem_in - den_sh) : rem_in;
        quo_next = quo_in;
        quo_next[SHIFT] = fits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_in;
        quo_reg <= quo_next;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;

endmodule

FILE: rtl/bhaskara_sine_approx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhaskara_sine_approx: Bhaskara I sine approximation, Q3.12 in, Q1.14 out
//
//   channel   signals                  direction  width
//   command   start, busy, angle       in/out     16 signed
//   result    done, sine_value         out        16 signed
//
// One word is taken every cycle; busy is never raised.
// Each result passes through 3 setup stages, a chain of 15 division cells
// (one quotient bit each) and one output stage.
// Reset clears every valid flag in the pipeline; words in flight are lost.
// The result is shown for one cycle with done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module bhaskara_sine_approx (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bsa_pkg::ANGLE_W-1:0]   angle,
    output logic                          done,
    output logic [bsa_pkg::SINE_W-1:0]    sine_value
);
    import bsa_pkg::*;

    bsa_ctl_t         chain_ctl [QUO_W+1];
    logic [DVD_W-1:0] chain_rem [QUO_W+1];
    logic [DEN_W-1:0] chain_den [QUO_W+1];
    logic [QUO_W-1:0] chain_quo [QUO_W+1];

    logic [QUO_W-1:0]  q_sat;
    logic [SINE_W-1:0] sine_next;
    logic [SINE_W-1:0] sine_reg;
    logic              done_reg;

    assign busy = 1'b0;

    // Reduce, multiply and set up the division
    bsa_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .angle    (angle),
        .ctl_out  (chain_ctl[0]),
        .dvd_out  (chain_rem[0]),
        .den_out  (chain_den[0])
    );

    assign chain_quo[0] = '0;

    // Division cells, most significant quotient bit first
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_cell
        bsa_div_cell #(
            .SHIFT (QUO_W - 1 - j)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (chain_ctl[j]),
            .rem_in  (chain_rem[j]),
            .den_in  (chain_den[j]),
            .quo_in  (chain_quo[j]),
            .ctl_out (chain_ctl[j+1]),
            .rem_out (chain_rem[j+1]),
            .den_out (chain_den[j+1]),
            .quo_out (chain_quo[j+1])
        );
    end

    // Clamp to one and apply the sign
    always_comb
    begin
        q_sat = (chain_quo[QUO_W] > ONE_Q14) ? ONE_Q14 : chain_quo[QUO_W];
        if (chain_ctl[QUO_W].neg)
            sine_next = -{{(SINE_W-QUO_W){1'b0}}, q_sat};
        else
            sine_next = {{(SINE_W-QUO_W){1'b0}}, q_sat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain_ctl[QUO_W].valid;
    end

    always_ff @(posedge clk)
    begin
        sine_reg <= sine_next;
    end

    assign done       = done_reg;
    assign sine_value = sine_reg;

endmodule

FILE: rtl/bsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_checker: port-level checks for the Bhaskara sine block
// Watches the command and result ports for busy, fixed latency, range and
// the zero-angle case. Attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsa_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [bsa_pkg::ANGLE_W-1:0]   angle,
    input  logic                          done,
    input  logic [bsa_pkg::SINE_W-1:0]    sine_value
);
    import bsa_pkg::*;

    localparam int CNT_W = $clog2(LATENCY + 1);

    logic [CNT_W-1:0] settle_cnt_reg;
    logic [CNT_W-1:0] settle_cnt_next;
    logic             settled;

    // Count cycles since reset release, stop at the pipeline depth
    always_comb
    begin
        if (settle_cnt_reg == CNT_W'(LATENCY))
            settle_cnt_next = settle_cnt_reg;
        else
            settle_cnt_next = settle_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_cnt_reg <= '0;
        else
            settle_cnt_reg <= settle_cnt_next;
    end

    assign settled = (settle_cnt_reg == CNT_W'(LATENCY));

    `BSA_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
    `BSA_ASSERT_IMPLY(a_done_has_word, done, $past(start && !busy, LATENCY),
        "result without a taken word")
    `BSA_ASSERT_IMPLY(a_word_gives_done, settled && $past(start && !busy, LATENCY), done,
        "taken word gave no result")
    `BSA_ASSERT_IMPLY(a_range, done,
        ($signed(sine_value) <= 16'sd16384) && ($signed(sine_value) >= -16'sd16384),
        "sine out of range")
    `BSA_ASSERT_IMPLY(a_zero, done && $past(start && (angle == '0), LATENCY),
        sine_value == '0, "zero angle gave nonzero sine")

endmodule

bind bhaskara_sine_approx bsa_checker u_bsa_checker (.*);

FILE: test/bhaskara_sine_approx_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhaskara_sine_approx_tb: self-checking bench for the Bhaskara sine block
// Feeds Q3.12 angles through the start/busy command port and checks every
// Q1.14 sine word on the done strobe. The expected value comes from an
// integer model kept in a small scoreboard class. Stimulus has a directed
// part (zero, +/-pi, pi/2 saturation, range wrap, field extremes), then
// random angles mixed over the full range, the principal range and the wrap
// boundaries. Random gaps run between words, with bursts of back-to-back
// words and full drains of the pipeline.
// ----------------------------------------------------------------------------
module bhaskara_sine_approx_tb;

    import bsa_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_WORDS  = 1000;
    localparam int MAX_GAP       = 18;
    localparam int STALL_LIMIT   = 1000;
    localparam int DIRECTED_N    = 22;

    // Q3.12 half and full turn, Q1.14 unity
    localparam longint unsigned HALF_TURN = 64'd12861;
    localparam int              FULL_TURN = 25722;
    localparam longint unsigned UNITY     = 64'd16384;

    typedef struct {
        logic [ANGLE_W-1:0] angle;
        logic [SINE_W-1:0]  sine;
    } sine_entry_t;

    // Predict each sine word and match it against the done strobe
    class sine_scoreboard;
        sine_entry_t expected_q[$];
        int          words_in  = 0;
        int          words_out = 0;
        int          errors    = 0;

        function automatic logic [SINE_W-1:0] sine_of(logic signed [ANGLE_W-1:0] ang);
            int              x;
            bit              neg;
            longint unsigned mag, prod, num, den, quo;
            logic [SINE_W-1:0] r;
            x = int'(ang);
            // fold into (-pi, pi]; one step is enough for any 16-bit angle
            if (x > int'(HALF_TURN))
                x = x - FULL_TURN;
            else if (x <= -int'(HALF_TURN))
                x = x + FULL_TURN;
            neg  = (x < 0);
            mag  = neg ? longint'(-x) : longint'(x);
            prod = mag * (HALF_TURN - mag);
            num  = prod * 16;
            den  = 5 * HALF_TURN * HALF_TURN - 4 * prod;
            quo  = ((num << 14) + (den >> 1)) / den;
            // clamp to one before the sign goes on
            if (quo > UNITY)
                quo = UNITY;
            r = quo[SINE_W-1:0];
            return neg ? -r : r;
        endfunction

        function void note_angle(logic [ANGLE_W-1:0] ang);
            sine_entry_t e;
            e.angle = ang;
            e.sine  = sine_of(ang);
            expected_q.push_back(e);
            words_in++;
        endfunction

        function void check_sine(logic [SINE_W-1:0] got);
            sine_entry_t e;
            words_out++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected sine word %0d with nothing pending",
                         $time, $signed(got));
            end
            else
            begin
                e = expected_q.pop_front();
                if (got !== e.sine)
                begin
                    errors++;
                    $display("%0t: sine_value mismatch for angle %0d: expected %0d, actual %0d",
                             $time, $signed(e.angle), $signed(e.sine), $signed(got));
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [ANGLE_W-1:0] angle = '0;
    logic               done;
    logic [SINE_W-1:0]  sine_value;

    sine_scoreboard sb = new;
    int             stall_cycles = 0;
    bit             burst_mode = 1'b0;

    int directed_angles [DIRECTED_N] = '{
        0, 1, -1, 12861, -12861, 12860, -12860, 12862, -12862,
        6430, 6431, 6432, -6431, 3215, -3215, 25722, -25722,
        32767, -32768, 19292, -19292, 21845
    };

    bhaskara_sine_approx DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .angle      (angle),
        .done       (done),
        .sine_value (sine_value)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Record accepted words, check results, watch for a stuck pipeline
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_angle(angle);
            if (done)
                sb.check_sine(sine_value);
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Idle for gap cycles, then present one word and hold it until taken
    task automatic send_word(input logic [ANGLE_W-1:0] ang, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        angle <= ang;
        do @(posedge clk); while (busy);
    endtask

    // Hold off the sender until every pending sine word has come back
    task automatic drain_pipeline();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic int draw_gap();
        if ($urandom_range(0, 39) == 0)
            burst_mode = ~burst_mode;
        return burst_mode ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Mix full-range angles, principal-range angles and wrap boundaries
    function automatic logic [ANGLE_W-1:0] draw_angle();
        int base;
        case ($urandom_range(0, 3))
            0, 1:    return ANGLE_W'($urandom_range(0, 65535));
            2:       return ANGLE_W'($urandom_range(0, FULL_TURN) - int'(HALF_TURN));
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       base = int'(HALF_TURN);
                    1:       base = -int'(HALF_TURN);
                    2:       base = FULL_TURN;
                    3:       base = -FULL_TURN;
                    4:       base = 6431;
                    default: base = 0;
                endcase
                return ANGLE_W'(base + int'($urandom_range(0, 8)) - 4);
            end
        endcase
    endfunction

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners, spaced and back to back
        foreach (directed_angles[i])
            send_word(directed_angles[i][ANGLE_W-1:0],
                      (i % 3 == 0) ? int'($urandom_range(0, 4)) : 0);
        drain_pipeline();

        // random angles with random gaps and an occasional full drain
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            send_word(draw_angle(), draw_gap());
            if (n % 250 == 249)
                drain_pipeline();
        end

        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        $display("Covered %0d angles (%0d directed, rest random over full range, +/-pi, +/-2pi)",
                 sb.words_in, DIRECTED_N);
        $display("Checked %0d sine words, %0d mismatches, %0d left pending",
                 sb.words_out, sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bsa_pkg.sv
rtl/bsa_prep.sv
rtl/bsa_div_cell.sv
rtl/bhaskara_sine_approx.sv
rtl/bsa_checker.sv
test/bhaskara_sine_approx_tb.sv
